FILE: hdl/tec_pkg.sv
// Package for the text encoding classifier: widths, class codes, masks and
// the running-state struct shared by the step logic and the top level.
// No dependencies.
`default_nettype none

package tec_pkg;

	localparam int BYTE_W   = 8;
	localparam int CLASS_W  = 2;
	localparam int HEAD_N   = 3;
	localparam int WIN_N    = 4;
	localparam int SEEN_W   = 3;
	localparam int SKIP_W   = 2;

	localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(5);

	typedef enum logic [CLASS_W-1:0] {
		CLASS_ANSI   = 2'd0,
		CLASS_UTF8   = 2'd1,
		CLASS_UTF16  = 2'd2,
		CLASS_BINARY = 2'd3
	} enc_class_t;

	// Marks and byte classes
	localparam logic [BYTE_W-1:0] BOM16_B0   = 8'hFF;
	localparam logic [BYTE_W-1:0] BOM16_B1   = 8'hFE;
	localparam logic [BYTE_W-1:0] BOM8_B0    = 8'hEF;
	localparam logic [BYTE_W-1:0] BOM8_B1    = 8'hBB;
	localparam logic [BYTE_W-1:0] BOM8_B2    = 8'hBF;
	localparam logic [BYTE_W-1:0] BAD_C0     = 8'hC0;
	localparam logic [BYTE_W-1:0] BAD_C1     = 8'hC1;
	localparam logic [BYTE_W-1:0] BAD_FROM   = 8'hF5;
	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_VAL  = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD3_VAL  = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
	localparam logic [BYTE_W-1:0] LEAD4_VAL  = 8'hF0;
	localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
	localparam logic [BYTE_W-1:0] CONT_VAL   = 8'h80;

	typedef struct packed {
		logic [HEAD_N-1:0][BYTE_W-1:0] head_bytes;
		logic [WIN_N-1:0][BYTE_W-1:0]  lookahead_window; // index 0 oldest
		logic [SEEN_W-1:0]             bytes_seen;
		logic                          odd_position;
		logic                          zero_word_found;
		logic                          zero_byte_found;
		logic                          forbidden_byte_found;
		logic                          sequence_error_found;
		logic                          multibyte_found;
		logic [SKIP_W-1:0]             continuations_to_skip;
	} tec_state_t;

endpackage

`default_nettype wire

FILE: hdl/tec_in_if.sv
// Input channel of the classifier: one buffer byte and its last marker per beat.
// Depends on tec_pkg.
`default_nettype none

interface tec_in_if import tec_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/tec_out_if.sv
// Result channel of the classifier: one encoding class per beat.
// Depends on tec_pkg.
`default_nettype none

interface tec_out_if import tec_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CLASS_W-1:0] encoding_class;

	modport source (output valid, output encoding_class, input ready);
	modport sink   (input valid, input encoding_class, output ready);
endinterface

`default_nettype wire

FILE: hdl/tec_step.sv
// Per-byte update of the classifier state and the class decision for a last byte.
// Purely combinational; depends on tec_pkg.
`default_nettype none

module tec_step import tec_pkg::*; (
	input  tec_state_t        cur,
	input  logic [BYTE_W-1:0] data_byte,
	output tec_state_t        nxt,
	output enc_class_t        encoding_class
);

	logic [SEEN_W-1:0] seen;
	logic [BYTE_W-1:0] lead;
	logic [1:0]        need;
	logic [WIN_N-1:1]  cont;
	logic              seq_ok;
	logic              bom16;
	logic              bom8;

	always_comb begin
		nxt  = cur;
		seen = (cur.bytes_seen < SEEN_MAX) ? cur.bytes_seen + SEEN_W'(1) : cur.bytes_seen;
		nxt.bytes_seen = seen;

		case (seen)
			SEEN_W'(1): nxt.head_bytes[0] = data_byte;
			SEEN_W'(2): nxt.head_bytes[1] = data_byte;
			SEEN_W'(3): nxt.head_bytes[2] = data_byte;
			default: ;
		endcase

		if (seen >= SEEN_W'(3) && data_byte == '0)
			nxt.zero_byte_found = 1'b1;
		if (seen >= SEEN_W'(3) && !cur.odd_position &&
		    cur.lookahead_window[2] == '0 && cur.lookahead_window[3] == '0)
			nxt.zero_word_found = 1'b1;
		if (data_byte == BAD_C0 || data_byte == BAD_C1 || data_byte >= BAD_FROM)
			nxt.forbidden_byte_found = 1'b1;

		// judge the oldest window byte as a lead byte
		lead = cur.lookahead_window[0];
		if ((lead & LEAD2_MASK) == LEAD2_VAL)
			need = 2'd1;
		else if ((lead & LEAD3_MASK) == LEAD3_VAL)
			need = 2'd2;
		else if ((lead & LEAD4_MASK) == LEAD4_VAL)
			need = 2'd3;
		else
			need = 2'd0;
		for (int k = 1; k < WIN_N; k++)
			cont[k] = (cur.lookahead_window[k] & CONT_MASK) == CONT_VAL;
		case (need)
			2'd1:    seq_ok = cont[1];
			2'd2:    seq_ok = cont[1] & cont[2];
			2'd3:    seq_ok = cont[1] & cont[2] & cont[3];
			default: seq_ok = 1'b1;
		endcase

		if (seen >= SEEN_MAX) begin
			if (cur.continuations_to_skip != '0) begin
				nxt.continuations_to_skip = cur.continuations_to_skip - SKIP_W'(1);
			end else if (need != 2'd0) begin
				if (seq_ok) begin
					nxt.multibyte_found       = 1'b1;
					nxt.continuations_to_skip = need;
				end else begin
					nxt.sequence_error_found = 1'b1;
				end
			end
		end

		nxt.lookahead_window = {data_byte, cur.lookahead_window[WIN_N-1:1]};
		nxt.odd_position     = ~cur.odd_position;

		bom16 = nxt.head_bytes[0] == BOM16_B0 && nxt.head_bytes[1] == BOM16_B1;
		bom8  = nxt.head_bytes[0] == BOM8_B0 && nxt.head_bytes[1] == BOM8_B1 &&
		        nxt.head_bytes[2] == BOM8_B2;

		if (seen < SEEN_W'(2))
			encoding_class = CLASS_ANSI;
		else if (nxt.zero_word_found)
			encoding_class = CLASS_BINARY;
		else if (nxt.zero_byte_found && cur.odd_position)
			encoding_class = CLASS_UTF16;
		else if (bom16)
			encoding_class = CLASS_UTF16;
		else if (seen < SEEN_W'(3))
			encoding_class = CLASS_ANSI;
		else if (bom8)
			encoding_class = CLASS_UTF8;
		else if (nxt.forbidden_byte_found || nxt.sequence_error_found)
			encoding_class = CLASS_ANSI;
		else
			encoding_class = nxt.multibyte_found ? CLASS_UTF8 : CLASS_ANSI;
	end

endmodule

`default_nettype wire

FILE: hdl/text_encoding_classifier.sv
// Text encoding classifier top level: input register, state register and
// result register around tec_step. Depends on tec_pkg, tec_in_if, tec_out_if.
//
// Usage:
//   in_ch carries one buffer byte per beat (data_byte) with final_byte set on
//   the last byte of the buffer. Buffers follow one another with no gap.
//   out_ch gives one beat per buffer, encoding_class: 0 ANSI, 1 UTF-8,
//   2 UTF-16LE, 3 binary. Bytes that are not last give no result.
//   Throughput: one byte per cycle, sustained, as long as out_ch is not
//   stalled. The class of a buffer reaches out_ch after its last byte is
//   taken, through the input register and then the result register.
//   Each byte passes one short compare-and-update stage against the running
//   state; the state clears itself after every last byte.
//   When out_ch stalls with a result waiting, the block still takes a byte
//   into its input register; further bytes wait until the result is taken.
//   Reset (arst_n low) clears the running state and drops any held beat.
`default_nettype none

module text_encoding_classifier import tec_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tec_in_if.sink     in_ch,
	tec_out_if.source  out_ch
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	tec_state_t        state_q;
	tec_state_t        state_nxt;
	enc_class_t        cls_nxt;
	logic              out_valid_q;
	enc_class_t        cls_q;
	logic              advance;

	tec_step u_step (
		.cur            (state_q),
		.data_byte      (byte_s1),
		.nxt            (state_nxt),
		.encoding_class (cls_nxt)
	);

	assign advance     = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.final_byte;
		end
	end

	// fold the byte into the state; a last byte returns the state to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= last_s1 ? tec_state_t'('0) : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cls_q <= cls_nxt;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.encoding_class = cls_q;

endmodule

`default_nettype wire
